// ===== src/spa_pkg.sv =====
`default_nettype none

package spa_pkg;

  // Field widths fixed by the transaction format.
  localparam int unsigned TickW     = 64;
  localparam int unsigned SysIdW    = 6;
  localparam int unsigned DurW      = 32;
  localparam int unsigned CountW    = 32;
  localparam int unsigned SumW      = 48;
  localparam int unsigned NumSysW   = 7;
  localparam int unsigned LimitW    = 11;
  localparam int unsigned StoredW   = 11;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 11;

  // Highest number of system indices the request format can address.
  localparam int unsigned SysIdSpan = 2 ** SysIdW;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_NUM_SYSTEMS  = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_LIMIT = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [NumSysW-1:0] NUM_SYSTEMS_RST  = 7'd0;
  localparam logic [LimitW-1:0]  SAMPLE_LIMIT_RST = 11'd1024;

  typedef enum logic {
    REQ_RECORD = 1'b0,
    REQ_CLEAR  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_STORED  = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_FULL    = 2'd2,
    ST_CLEARED = 2'd3
  } status_e;

  typedef struct packed {
    req_e              req_type;
    logic [TickW-1:0]  tick;
    logic [SysIdW-1:0] system_id;
    logic [DurW-1:0]   duration;
  } spa_in_t;

  typedef struct packed {
    status_e            status;
    logic [CountW-1:0]  sys_call_count;
    logic [SumW-1:0]    sys_total;
    logic [DurW-1:0]    sys_max;
    logic [CountW-1:0]  all_span_count;
    logic [SumW-1:0]    all_total;
    logic               overflowed;
    logic [StoredW-1:0] stored_count;
  } spa_out_t;

  // One per-system aggregate entry.
  typedef struct packed {
    logic [CountW-1:0] calls;
    logic [SumW-1:0]   sum;
    logic [DurW-1:0]   peak;
  } agg_entry_t;

  // One retained span in the trace store.
  typedef struct packed {
    logic [TickW-1:0]  tick;
    logic [SysIdW-1:0] system_id;
    logic [DurW-1:0]   length;
  } trace_entry_t;

  // Saturating increment of a count.
  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] a);
    logic [CountW-1:0] r;
    r = (a == '1) ? a : a + CountW'(1);
    return r;
  endfunction

  // Saturating add of a duration to a total.
  function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] a,
                                              input logic [DurW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + {{(SumW + 1 - DurW){1'b0}}, b};
    return s[SumW] ? '1 : s[SumW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/spa_agg_store.sv =====
`default_nettype none

module spa_agg_store #(
  parameter int unsigned Depth = 64,
  parameter int unsigned IdxW  = 6
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    rd_en_i,
  input  wire logic [IdxW-1:0]         rd_idx_i,
  input  wire logic                    wr_en_i,
  input  wire logic [IdxW-1:0]         wr_idx_i,
  input  wire spa_pkg::agg_entry_t     wr_data_i,
  input  wire logic                    clr_i,
  output      spa_pkg::agg_entry_t     rd_data_o
);
  import spa_pkg::*;

  agg_entry_t       mem_q [Depth];
  agg_entry_t       rdata_q;
  logic [IdxW-1:0]  rd_idx_q;
  logic [Depth-1:0] vld_q;
  logic             wb_vld_q;
  logic [IdxW-1:0]  wb_idx_q;
  agg_entry_t       wb_data_q;

  // Single write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q  <= mem_q[rd_idx_i];
      rd_idx_q <= rd_idx_i;
    end
  end

  // Entry valid bits; a clear drops every entry back to zero at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      wb_vld_q <= 1'b0;
    end else if (clr_i) begin
      vld_q    <= '0;
      wb_vld_q <= 1'b0;
    end else if (wr_en_i) begin
      vld_q[wr_idx_i] <= 1'b1;
      wb_vld_q        <= 1'b1;
    end
  end

  // Last write-back, kept to cover a read that raced the write.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      wb_idx_q  <= wr_idx_i;
      wb_data_q <= wr_data_i;
    end
  end

  // Current view of the entry: forwarded, stored, or reset value.
  always_comb begin
    priority if (wb_vld_q && (wb_idx_q == rd_idx_q)) begin
      rd_data_o = wb_data_q;
    end else if (vld_q[rd_idx_q]) begin
      rd_data_o = rdata_q;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

`default_nettype wire

// ===== src/spa_trace_store.sv =====
`default_nettype none

module spa_trace_store #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned IdxW  = 10
) (
  input  wire logic                  clk_i,
  input  wire logic                  wr_en_i,
  input  wire logic [IdxW-1:0]       wr_idx_i,
  input  wire spa_pkg::trace_entry_t wr_data_i
);
  import spa_pkg::*;

  trace_entry_t mem_q [Depth];

  // Spans are appended in arrival order at the current fill position.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/span_profile_aggregator.sv =====
`default_nettype none

// Profiling span recorder. Each record transaction to a known system updates
// its call count, duration total and peak plus the global span count and
// total, then appends the span to the trace store or sets the sticky overflow
// flag; a clear transaction zeroes all of that at once. Exactly one result
// transaction follows each request. The block takes one request per cycle
// while the output is not stalled. The per-system aggregates sit in a memory
// with one registered read port and one write port, read on acceptance and
// written back when the request leaves the update stage, with the last
// write-back forwarded when consecutive requests hit the same system.
// Configuration writes must only be issued while no request is in flight.
module span_profile_aggregator #(
  parameter int unsigned SAMPLE_DEPTH = 1024,
  parameter int unsigned MAX_SYSTEMS  = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [spa_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [spa_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output      logic                            in_ready_o,
  input  wire spa_pkg::spa_in_t                in_data_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  output      spa_pkg::spa_out_t               out_data_o
);
  import spa_pkg::*;

  // Only indices the request format can carry ever reach the memory.
  localparam int unsigned AggDepth = (MAX_SYSTEMS < SysIdSpan) ? MAX_SYSTEMS : SysIdSpan;
  localparam int unsigned AggIdxW  = (AggDepth > 1) ? $clog2(AggDepth) : 1;
  localparam int unsigned TrIdxW   = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int unsigned FillW    = $clog2(SAMPLE_DEPTH + 1);

  logic [NumSysW-1:0] num_systems_q;
  logic [LimitW-1:0]  sample_limit_q;

  logic       s1_vld_q;
  spa_in_t    s1_req_q;
  logic       out_vld_q;
  spa_out_t   out_data_q, out_data_d;

  logic [FillW-1:0]  fill_q, fill_d;
  logic [CountW-1:0] span_cnt_q, span_cnt_d;
  logic [SumW-1:0]   dur_tot_q, dur_tot_d;
  logic              dropped_q, dropped_d;

  logic       in_accept, out_free, s1_fire;
  logic       is_clear, sys_known, store_full;
  agg_entry_t agg_cur, agg_new;
  logic       agg_we, agg_clr, trace_we;
  trace_entry_t trace_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_systems_q  <= NUM_SYSTEMS_RST;
      sample_limit_q <= SAMPLE_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUM_SYSTEMS:  num_systems_q  <= cfg_wdata_i[NumSysW-1:0];
        CFG_SAMPLE_LIMIT: sample_limit_q <= cfg_wdata_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the output register frees the update stage as it drains.
  assign out_free   = !out_vld_q || out_ready_i;
  assign s1_fire    = s1_vld_q && out_free;
  assign in_ready_o = !s1_vld_q || out_free;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_vld_q <= 1'b1;
      end else if (s1_fire) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_fire) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_req_q <= in_data_i;
    end
    if (s1_fire) begin
      out_data_q <= out_data_d;
    end
  end

  // Per-system aggregates.
  spa_agg_store #(
    .Depth(AggDepth),
    .IdxW (AggIdxW)
  ) u_agg_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_accept),
    .rd_idx_i (in_data_i.system_id[AggIdxW-1:0]),
    .wr_en_i  (agg_we),
    .wr_idx_i (s1_req_q.system_id[AggIdxW-1:0]),
    .wr_data_i(agg_new),
    .clr_i    (agg_clr),
    .rd_data_o(agg_cur)
  );

  // Span trace store, appended at the fill position.
  spa_trace_store #(
    .Depth(SAMPLE_DEPTH),
    .IdxW (TrIdxW)
  ) u_trace_store (
    .clk_i    (clk_i),
    .wr_en_i  (trace_we),
    .wr_idx_i (fill_q[TrIdxW-1:0]),
    .wr_data_i(trace_data)
  );

  // Classify the request in the update stage.
  assign is_clear   = (s1_req_q.req_type == REQ_CLEAR);
  assign sys_known  = ({1'b0, s1_req_q.system_id} < num_systems_q) &&
                      (32'(s1_req_q.system_id) < 32'(MAX_SYSTEMS));
  assign store_full = (32'(fill_q) >= 32'(sample_limit_q)) ||
                      (32'(fill_q) >= 32'(SAMPLE_DEPTH));

  assign agg_we   = s1_fire && !is_clear && sys_known;
  assign agg_clr  = s1_fire && is_clear;
  assign trace_we = agg_we && !store_full;

  assign trace_data.tick      = s1_req_q.tick;
  assign trace_data.system_id = s1_req_q.system_id;
  assign trace_data.length    = s1_req_q.duration;

  // Updated aggregate entry.
  always_comb begin
    agg_new.calls = sat_inc(agg_cur.calls);
    agg_new.sum   = sat_add(agg_cur.sum, s1_req_q.duration);
    agg_new.peak  = (s1_req_q.duration > agg_cur.peak) ? s1_req_q.duration : agg_cur.peak;
  end

  // Global totals and the result transaction.
  always_comb begin
    fill_d     = fill_q;
    span_cnt_d = span_cnt_q;
    dur_tot_d  = dur_tot_q;
    dropped_d  = dropped_q;
    out_data_d = '0;
    if (is_clear) begin
      fill_d            = '0;
      span_cnt_d        = '0;
      dur_tot_d         = '0;
      dropped_d         = 1'b0;
      out_data_d.status = ST_CLEARED;
    end else begin
      if (sys_known) begin
        span_cnt_d = sat_inc(span_cnt_q);
        dur_tot_d  = sat_add(dur_tot_q, s1_req_q.duration);
        if (store_full) begin
          dropped_d         = 1'b1;
          out_data_d.status = ST_FULL;
        end else begin
          fill_d            = fill_q + FillW'(1);
          out_data_d.status = ST_STORED;
        end
        out_data_d.sys_call_count = agg_new.calls;
        out_data_d.sys_total      = agg_new.sum;
        out_data_d.sys_max        = agg_new.peak;
      end else begin
        out_data_d.status = ST_UNKNOWN;
      end
      out_data_d.all_span_count = span_cnt_d;
      out_data_d.all_total      = dur_tot_d;
      out_data_d.overflowed     = dropped_d;
      out_data_d.stored_count   = StoredW'(fill_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      span_cnt_q <= '0;
      dur_tot_q  <= '0;
      dropped_q  <= 1'b0;
    end else if (s1_fire) begin
      fill_q     <= fill_d;
      span_cnt_q <= span_cnt_d;
      dur_tot_q  <= dur_tot_d;
      dropped_q  <= dropped_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== sim/tb_span_profile_aggregator.sv =====
`timescale 1ns / 100ps

module tb_span_profile_aggregator;
  import spa_pkg::*;

  localparam int unsigned SysSlots      = 64;
  localparam int unsigned TraceDepth    = 1024;
  localparam int unsigned ClkPeriod     = 12;
  localparam int unsigned LongHold      = 400;
  localparam int unsigned SatItems      = 40;
  localparam longint     TimeoutCycles = 4000000;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_CADENCE
  } rx_mode_e;

  // Clock, reset and block inputs, all known from time zero.
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = CFG_NUM_SYSTEMS;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  spa_in_t             in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  spa_out_t            out_data_o;

  // Stimulus and expected-result stores.
  spa_in_t  pending_q[$];
  spa_out_t expect_q[$];
  bit       send_hold      = 1'b1;
  int       offered_total  = 0;
  int       accepted_total = 0;
  int       mismatch_count = 0;
  int       results_seen   = 0;
  int       cfg_writes     = 0;
  int       status_seen[4] = '{0, 0, 0, 0};
  int       stall_req      = 0;

  // Shadow copy of the profiler state and configuration.
  logic [NumSysW-1:0] cfg_nsys  = NUM_SYSTEMS_RST;
  logic [LimitW-1:0]  cfg_limit = SAMPLE_LIMIT_RST;
  logic [CountW-1:0]  sys_calls [SysSlots];
  logic [SumW-1:0]    sys_sum   [SysSlots];
  logic [DurW-1:0]    sys_peak  [SysSlots];
  logic [CountW-1:0]  span_count;
  logic [SumW-1:0]    span_sum;
  int unsigned        trace_fill;
  logic               drop_seen;

  span_profile_aggregator #(
    .SAMPLE_DEPTH(TraceDepth),
    .MAX_SYSTEMS (SysSlots)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Count that stops at its top value.
  function automatic logic [CountW-1:0] bump_count(input logic [CountW-1:0] c);
    return (c == {CountW{1'b1}}) ? c : c + 1'b1;
  endfunction

  // Duration total that sticks at its top value.
  function automatic logic [SumW-1:0] add_span(input logic [SumW-1:0] acc,
                                               input logic [DurW-1:0] d);
    logic [SumW:0] wide;
    wide = {1'b0, acc} + d;
    return (wide > {1'b0, {SumW{1'b1}}}) ? {SumW{1'b1}} : wide[SumW-1:0];
  endfunction

  function automatic void wipe_profile();
    for (int k = 0; k < SysSlots; k++) begin
      sys_calls[k] = '0;
      sys_sum[k]   = '0;
      sys_peak[k]  = '0;
    end
    span_count = '0;
    span_sum   = '0;
    trace_fill = 0;
    drop_seen  = 1'b0;
  endfunction

  // Applies one accepted request to the shadow state and returns its result.
  function automatic spa_out_t profile_predict(input spa_in_t rq);
    spa_out_t    r;
    int unsigned nsys;
    int unsigned cap;
    int unsigned id;
    r = '0;
    if (rq.req_type == REQ_CLEAR) begin
      wipe_profile();
      r.status = ST_CLEARED;
      return r;
    end
    nsys = (cfg_nsys > SysSlots) ? SysSlots : 32'(cfg_nsys);
    cap  = (cfg_limit > TraceDepth) ? TraceDepth : 32'(cfg_limit);
    id   = 32'(rq.system_id);
    if (id >= nsys) begin
      r.status = ST_UNKNOWN;
    end else begin
      sys_calls[id] = bump_count(sys_calls[id]);
      sys_sum[id]   = add_span(sys_sum[id], rq.duration);
      if (rq.duration > sys_peak[id]) sys_peak[id] = rq.duration;
      span_count = bump_count(span_count);
      span_sum   = add_span(span_sum, rq.duration);
      if (trace_fill >= cap) begin
        drop_seen = 1'b1;
        r.status  = ST_FULL;
      end else begin
        trace_fill++;
        r.status = ST_STORED;
      end
      r.sys_call_count = sys_calls[id];
      r.sys_total      = sys_sum[id];
      r.sys_max        = sys_peak[id];
    end
    r.all_span_count = span_count;
    r.all_total      = span_sum;
    r.overflowed     = drop_seen;
    r.stored_count   = trace_fill[StoredW-1:0];
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] want_v,
                               input logic [63:0] got_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] mismatch in %s at result %0d: expected 0x%0h, got 0x%0h",
               $time, what, results_seen, want_v, got_v);
  endtask

  // Compares one result transaction with the oldest expectation.
  task automatic check_result(input spa_out_t got);
    spa_out_t want;
    if (expect_q.size() == 0) begin
      flag_mismatch("result with nothing expected, status", '0, 64'(got.status));
      return;
    end
    want = expect_q.pop_front();
    status_seen[want.status]++;
    if (got.status !== want.status)
      flag_mismatch("status", 64'(want.status), 64'(got.status));
    if (got.sys_call_count !== want.sys_call_count)
      flag_mismatch("sys_call_count", 64'(want.sys_call_count), 64'(got.sys_call_count));
    if (got.sys_total !== want.sys_total)
      flag_mismatch("sys_total", 64'(want.sys_total), 64'(got.sys_total));
    if (got.sys_max !== want.sys_max)
      flag_mismatch("sys_max", 64'(want.sys_max), 64'(got.sys_max));
    if (got.all_span_count !== want.all_span_count)
      flag_mismatch("all_span_count", 64'(want.all_span_count), 64'(got.all_span_count));
    if (got.all_total !== want.all_total)
      flag_mismatch("all_total", 64'(want.all_total), 64'(got.all_total));
    if (got.overflowed !== want.overflowed)
      flag_mismatch("overflowed", 64'(want.overflowed), 64'(got.overflowed));
    if (got.stored_count !== want.stored_count)
      flag_mismatch("stored_count", 64'(want.stored_count), 64'(got.stored_count));
  endtask

  // Driver: offers queued requests in bursts with random gaps.
  int       burst_left = 0;
  int       gap_left   = 0;
  logic     nxt_valid;
  spa_in_t  nxt_req;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      nxt_valid = in_valid_i;
      nxt_req   = in_data_i;
      if (in_valid_i && in_ready_o) begin
        expect_q.insert(expect_q.size(), profile_predict(in_data_i));
        accepted_total++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!send_hold && pending_q.size() != 0) begin
          nxt_req   = pending_q.pop_front();
          nxt_valid = 1'b1;
          offered_total++;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 15) == 0) begin
            burst_left = 400;
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
      in_valid_i <= nxt_valid;
      in_data_i  <= nxt_req;
    end
  end

  // Monitor: checks results and stalls the output on shifting patterns.
  rx_mode_e rx_mode   = RX_OPEN;
  int       mode_left = 0;
  int       hold_left = 0;
  int       stall_ack = 0;
  int       rx_cycle  = 0;
  logic     nxt_ready;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        check_result(out_data_o);
      end
      rx_cycle++;
      if (stall_req != stall_ack) begin
        stall_ack = stall_req;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 200);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          RX_OPEN:    nxt_ready = 1'b1;
          RX_COIN:    nxt_ready = 1'($urandom_range(0, 1));
          RX_SPARSE:  nxt_ready = ($urandom_range(0, 3) == 0);
          default:    nxt_ready = (rx_cycle % 4 != 3);
        endcase
      end
      out_ready_i <= nxt_ready;
    end
  end

  // Register write while the block is idle; the shadow copy follows it.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_NUM_SYSTEMS) cfg_nsys = val[NumSysW-1:0];
    else cfg_limit = val[LimitW-1:0];
    cfg_writes++;
  endtask

  // Lets the sender run until every queued request has its result back.
  task automatic run_until_drained();
    send_hold = 1'b0;
    do @(posedge clk_i);
    while (!(pending_q.size() == 0 && accepted_total == offered_total &&
             expect_q.size() == 0));
    send_hold = 1'b1;
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_span(input logic [TickW-1:0] tk, input logic [SysIdW-1:0] id,
                           input logic [DurW-1:0] d);
    spa_in_t rq;
    rq.req_type  = REQ_RECORD;
    rq.tick      = tk;
    rq.system_id = id;
    rq.duration  = d;
    pending_q.insert(pending_q.size(), rq);
  endtask

  task automatic push_clear();
    spa_in_t rq;
    rq.req_type  = REQ_CLEAR;
    rq.tick      = {$urandom, $urandom};
    rq.system_id = SysIdW'($urandom_range(0, 63));
    rq.duration  = $urandom;
    pending_q.insert(pending_q.size(), rq);
  endtask

  // Mostly spans to registered systems, with repeats of the same system,
  // some unknown indices and occasional clears.
  task automatic queue_random_spans(input int n, input int clear_pct);
    int unsigned eff;
    int unsigned roll;
    logic [SysIdW-1:0] id;
    logic [SysIdW-1:0] last_id;
    logic [DurW-1:0]   d;
    eff     = (cfg_nsys > SysSlots) ? SysSlots : 32'(cfg_nsys);
    last_id = '0;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < clear_pct) begin
        push_clear();
      end else begin
        if (roll < 85 && eff > 0) begin
          if ($urandom_range(0, 9) < 3 && last_id < eff) id = last_id;
          else id = SysIdW'($urandom_range(0, eff - 1));
        end else begin
          id = SysIdW'($urandom_range(0, 63));
        end
        case ($urandom_range(0, 5))
          0:       d = '0;
          1:       d = '1;
          2:       d = $urandom_range(0, 2048);
          default: d = $urandom;
        endcase
        push_span({$urandom, $urandom}, id, d);
        last_id = id;
      end
    end
  endtask

  // Main sequence.
  initial begin
    wipe_profile();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset configuration registers no system, so the first span is rejected.
    push_span(64'd1, 6'd0, 32'd10);
    run_until_drained();

    // Four systems and a tiny store: boundaries, peaks, overflow and clear.
    write_reg(CFG_NUM_SYSTEMS, 11'd4);
    write_reg(CFG_SAMPLE_LIMIT, 11'd3);
    push_span('0, 6'd0, '0);
    push_span('1, 6'd3, '1);
    push_span(64'd5, 6'd4, 32'd1);
    push_span(64'd6, 6'd63, 32'd1);
    push_span(64'd7, 6'd0, 32'd5);
    push_span(64'd8, 6'd1, 32'd7);
    push_span(64'd9, 6'd1, 32'd3);
    push_clear();
    push_span(64'd10, 6'd2, 32'd1);
    push_span(64'd11, 6'd2, 32'd9);
    push_span(64'd12, 6'd2, 32'd2);
    run_until_drained();

    // Oversized registers act as the full system count and store depth.
    write_reg(CFG_NUM_SYSTEMS, 11'h7FF);
    write_reg(CFG_SAMPLE_LIMIT, 11'h7FF);
    push_span(64'h8000_0000_0000_0000, 6'd63, 32'd100);
    push_span(64'h1234_5678_9ABC_DEF0, 6'd40, '1);
    push_span(64'h0FED_CBA9_8765_4321, 6'd40, '1);
    run_until_drained();

    // Limit lowered below the current fill, then a zero limit.
    write_reg(CFG_SAMPLE_LIMIT, 11'd1);
    push_span(64'd20, 6'd5, 32'd4);
    run_until_drained();
    write_reg(CFG_SAMPLE_LIMIT, 11'd0);
    push_span(64'd21, 6'd5, 32'd6);
    push_clear();
    push_span(64'd22, 6'd5, 32'd6);
    run_until_drained();
    write_reg(CFG_NUM_SYSTEMS, 11'd64);
    write_reg(CFG_SAMPLE_LIMIT, 11'd1);
    push_span(64'd23, 6'd63, 32'd8);
    push_span(64'd24, 6'd63, 32'd8);
    run_until_drained();

    // Random phases, each under its own configuration.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(CFG_NUM_SYSTEMS, 11'd64); write_reg(CFG_SAMPLE_LIMIT, 11'd1024); end
        1: begin write_reg(CFG_NUM_SYSTEMS, 11'd1);  write_reg(CFG_SAMPLE_LIMIT, 11'd5); end
        2: begin
          write_reg(CFG_NUM_SYSTEMS, 11'd8);
          write_reg(CFG_SAMPLE_LIMIT, CfgDataW'($urandom_range(0, 60)));
        end
        3: begin write_reg(CFG_NUM_SYSTEMS, 11'd63); write_reg(CFG_SAMPLE_LIMIT, 11'd40); end
        4: begin
          write_reg(CFG_NUM_SYSTEMS, CfgDataW'($urandom_range(0, 2047)));
          write_reg(CFG_SAMPLE_LIMIT, CfgDataW'($urandom_range(0, 2047)));
        end
        5: begin write_reg(CFG_NUM_SYSTEMS, 11'd0);  write_reg(CFG_SAMPLE_LIMIT, 11'd10); end
        6: begin
          write_reg(CFG_NUM_SYSTEMS, CfgDataW'($urandom_range(1, 64)));
          write_reg(CFG_SAMPLE_LIMIT, 11'd0);
        end
        default: begin
          write_reg(CFG_NUM_SYSTEMS, 11'd100);
          write_reg(CFG_SAMPLE_LIMIT, 11'd2047);
        end
      endcase
      if (ph == 5) begin
        queue_random_spans(60, 5);
      end else if (ph == 4) begin
        // Sender stops mid-phase until all results are back, then resumes.
        queue_random_spans(110, 5);
        run_until_drained();
        queue_random_spans(110, 5);
      end else begin
        queue_random_spans(220, (ph == 1) ? 8 : 4);
      end
      // Receiver holds off for a long stretch so the block backs up.
      if (ph == 2) stall_req++;
      run_until_drained();
    end

    // A run of maximal spans, mostly to one system, checks large sums and
    // peaks starting from a cleared profile.
    push_clear();
    run_until_drained();
    write_reg(CFG_NUM_SYSTEMS, 11'd64);
    write_reg(CFG_SAMPLE_LIMIT, 11'd1024);
    for (int i = 0; i < SatItems; i++)
      push_span({$urandom, $urandom}, (i % 97 == 0) ? 6'($urandom_range(1, 63)) : 6'd0,
                '1);
    for (int i = 0; i < 8; i++) push_span({$urandom, $urandom}, 6'($urandom_range(0, 3)),
                                          $urandom_range(0, 100));
    run_until_drained();

    repeat (8) @(posedge clk_i);
    $display("Checked %0d results (%0d stored, %0d unknown system, %0d store full,",
             results_seen, status_seen[ST_STORED], status_seen[ST_UNKNOWN],
             status_seen[ST_FULL]);
    $display("  %0d clears) over %0d register writes; %0d field mismatches.",
             status_seen[ST_CLEARED], cfg_writes, mismatch_count);
    if (mismatch_count == 0 && expect_q.size() == 0) begin
      $display("span_profile_aggregator verification clean");
    end else begin
      $display("span_profile_aggregator verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("Timeout with %0d results still expected.", expect_q.size());
    $display("span_profile_aggregator verification failed");
    $finish;
  end

endmodule
